// ===== design/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// Depends on nothing; used by every module of the block.
package bsa_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;  // default bitmap size
   localparam int MAP_LIMIT          = 64;  // largest bitmap the 6-bit index can name
   localparam int COUNT_W            = 7;   // request count and active length width
   localparam int SLOT_W             = 6;   // slot index width
   localparam int GROUP_W            = 8;   // bits per group in the free/used count
   localparam int GROUP_CNT_W        = 4;   // width of one group's count

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [COUNT_W-1:0]   request_count;
   } req_word_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot_index;
      status_type           status;
      logic                 last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic count_en;
      logic emit_slot;
      logic emit_empty;
      logic emit_short;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic count_zero;
      logic avail_ok;
      logic out_free;
      logic last_slot;
   } dp_status_type;

endpackage

// ===== design/bitmap_slot_allocator_unit.sv =====
// Top level of the bitmap slot allocator: controller plus datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
//
// Keeps an occupancy bitmap (one bit per slot, all free after reset) and
// serves allocate and release requests. An allocate request for N slots
// takes the N lowest free active slots, marks them used and returns one
// word per slot in ascending index order; a release does the same for the
// N lowest used active slots. The final word of each request has last set.
// A count of zero gives a single word with status empty; a request that
// cannot be met in full gives a single word with status short and leaves
// the bitmap alone. csr_wdata sets the number of active low slots, saturated
// to the bitmap size; slots above it are neither read nor changed. Write it
// only while the block is idle. One request is handled at a time. A request
// is loaded, its matching slots are counted into per-group registers and the
// sum is checked against N; empty and short results leave at that check, else
// slots follow one per cycle through the lowest-set-bit priority encoder.
// Results sit in an output register, so a stalled rsp_ready holds the emit phase.
module bitmap_slot_allocator_unit
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  req_word_type       req_word,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_word_type       rsp_word,
   // active length register
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequence each request: load, count, check, then emit slot by slot
   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Hold the bitmap, count matches, pick the lowest and register results
   bsa_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

endmodule

// ===== design/bsa_ctrl.sv =====
// Sequencing state machine of the bitmap slot allocator.
// Depends on bsa_pkg; drives the datapath through ctrl_cmd_type.
module bsa_ctrl
   import bsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.load_req = 1'b1;
               state_in          = ST_COUNT;
            end
         end
         ST_COUNT: begin
            ctrl_cmd.count_en = 1'b1;
            state_in          = ST_CHECK;
         end
         ST_CHECK: begin
            if (dp_status.count_zero) begin
               if (dp_status.out_free) begin
                  ctrl_cmd.emit_empty = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else if (!dp_status.avail_ok) begin
               if (dp_status.out_free) begin
                  ctrl_cmd.emit_short = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (dp_status.out_free) begin
               ctrl_cmd.emit_slot = 1'b1;
               if (dp_status.last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Only one kind of result may be produced per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.emit_slot, ctrl_cmd.emit_empty, ctrl_cmd.emit_short}))
      else $error("more than one result kind in one cycle");

   // A request is taken only when the previous one has finished; each load must lead to the count state
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_req |=> state_ff == ST_COUNT)
      else $error("request load did not start a count");

   // Leaving the emit phase only on the final slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |-> ctrl_cmd.emit_slot
                                                       && dp_status.last_slot)
      else $error("emit phase left early");

endmodule

// ===== design/bsa_datapath.sv =====
// Occupancy bitmap, availability count, priority encoder and result register.
// Depends on bsa_pkg; commanded by bsa_ctrl.
module bsa_datapath
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  req_word_type       req_word,
   output rsp_word_type       rsp_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ctrl_cmd_type       ctrl_cmd,
   output dp_status_type      dp_status
);

   localparam int MAP_BITS   = (SLOT_COUNT < MAP_LIMIT) ? SLOT_COUNT : MAP_LIMIT;
   localparam int IDX_W      = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
   localparam int NUM_GROUPS = (MAP_BITS + GROUP_W - 1) / GROUP_W;
   localparam int PAD_W      = NUM_GROUPS * GROUP_W;

   logic [MAP_BITS-1:0]    occ_ff, occ_in;
   logic [MAP_BITS-1:0]    active_mask_ff, active_mask_in;
   cmd_type                cmd_ff;
   logic [COUNT_W-1:0]     remaining_ff, remaining_in;
   logic [GROUP_CNT_W-1:0] group_cnt_ff [NUM_GROUPS];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [COUNT_W-1:0]     len_sat;
   logic [MAP_BITS-1:0]    match;
   logic [PAD_W-1:0]       match_pad;
   logic [MAP_BITS-1:0]    lowest;
   logic [IDX_W-1:0]       lowest_idx;
   logic [COUNT_W-1:0]     avail_sum;
   logic                   out_free;

   // Active mask, worked out once per register write
   always_comb begin
      len_sat = (csr_wdata > COUNT_W'(MAP_BITS)) ? COUNT_W'(MAP_BITS) : csr_wdata;
      for (int i = 0; i < MAP_BITS; i++) begin
         active_mask_in[i] = COUNT_W'(i) < len_sat;
      end
   end

   // Matching slots: used for a release, free for an allocate
   always_comb begin
      match     = ((cmd_ff == CMD_RELEASE) ? occ_ff : ~occ_ff) & active_mask_ff;
      match_pad = PAD_W'(match);
      lowest    = match & (~match + MAP_BITS'(1));
      lowest_idx = '0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (lowest[i]) begin
            lowest_idx = lowest_idx | IDX_W'(i);
         end
      end
      avail_sum = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         avail_sum = avail_sum + COUNT_W'(group_cnt_ff[g]);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      occ_in       = occ_ff;
      remaining_in = remaining_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (ctrl_cmd.load_req) begin
         remaining_in = req_word.request_count;
      end
      if (ctrl_cmd.emit_slot) begin
         occ_in                 = occ_ff ^ lowest;
         remaining_in           = remaining_ff - COUNT_W'(1);
         rsp_valid_in           = 1'b1;
         rsp_word_in.slot_index = SLOT_W'(lowest_idx);
         rsp_word_in.status     = STATUS_OK;
         rsp_word_in.last       = (remaining_ff == COUNT_W'(1));
      end
      if (ctrl_cmd.emit_empty || ctrl_cmd.emit_short) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.slot_index = '0;
         rsp_word_in.status     = ctrl_cmd.emit_empty ? STATUS_EMPTY : STATUS_SHORT;
         rsp_word_in.last       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff         <= '0;
         active_mask_ff <= '1;
         remaining_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            active_mask_ff <= active_mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (ctrl_cmd.load_req) begin
         cmd_ff <= req_word.cmd;
      end
      if (ctrl_cmd.count_en) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_cnt_ff[g] <= GROUP_CNT_W'($countones(match_pad[g*GROUP_W +: GROUP_W]));
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign dp_status.count_zero = (remaining_ff == '0);
   assign dp_status.avail_ok   = (avail_sum >= remaining_ff);
   assign dp_status.out_free   = out_free;
   assign dp_status.last_slot  = (remaining_ff == COUNT_W'(1));

   // An emitted slot always has a count behind it and a matching bit to take
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit_slot |-> (remaining_ff != '0) && (match != '0))
      else $error("slot emitted with nothing to take");

   // Each emitted slot flips exactly one bitmap bit
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit_slot |=> $countones(occ_ff ^ $past(occ_ff)) == 1)
      else $error("bitmap changed by other than one bit");

   // Error and empty results never touch the bitmap
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.emit_empty || ctrl_cmd.emit_short) |=> $stable(occ_ff))
      else $error("bitmap changed by a failed request");

   // A result that is not ok carries slot zero and closes its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.status != STATUS_OK)
         |-> (rsp_word_ff.slot_index == '0) && rsp_word_ff.last)
      else $error("bad error result");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for bitmap_slot_allocator_unit: a bit-accurate occupancy
// predictor checks every result word in order under random idling.
// Depends on bsa_pkg and the allocator RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsa_pkg::*;

   localparam int RESET_CYCLES      = 7;
   localparam int IDLE_PERCENT      = 26;
   localparam int STALL_HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT    = 5000;   // cycles without any handshake
   localparam int DRAIN_CYCLES      = 8;      // extra wait after the last word is taken
   localparam int SLOT_TOTAL        = (SLOT_COUNT_DEFAULT < MAP_LIMIT) ?
                                      SLOT_COUNT_DEFAULT : MAP_LIMIT;

   // Drive every input to a known value from time zero.
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_word  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_we    = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata = '0;

   // Predictor state: occupancy bitmap and the saturated active length.
   logic [MAP_LIMIT-1:0] slot_map  = '0;
   int unsigned          slot_span = SLOT_TOTAL;
   rsp_word_type         slot_words_due[$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned stall_left     = 0;
   bit          stall_go       = 1'b0;
   bit          idling_on      = 1'b1;

   bitmap_slot_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Count active slots that a request of this command could take:
   // free slots for an allocate, used slots for a release.
   function automatic int unsigned matching_slots(cmd_type c);
      int unsigned hits;
      hits = 0;
      for (int i = 0; i < slot_span; i++)
         if (slot_map[i] == (c == CMD_RELEASE)) hits++;
      return hits;
   endfunction

   // Work out the words that one accepted request gives and update the map.
   // A zero count or a request that cannot be met in full leaves the map alone
   // and gives a single word; otherwise walk up from slot 0 and flip the
   // lowest matching slots, one word each, last on the final one.
   function automatic void predict_request(req_word_type w);
      int unsigned left;
      logic        want_used;
      want_used = (w.cmd == CMD_RELEASE);
      if (w.request_count == '0) begin
         slot_words_due.push_back('{slot_index: '0, status: STATUS_EMPTY, last: 1'b1});
      end else if (matching_slots(w.cmd) < 32'(w.request_count)) begin
         slot_words_due.push_back('{slot_index: '0, status: STATUS_SHORT, last: 1'b1});
      end else begin
         left = 32'(w.request_count);
         for (int i = 0; i < slot_span && left != 0; i++) begin
            if (slot_map[i] == want_used) begin
               slot_map[i] = ~want_used;
               left--;
               slot_words_due.push_back('{slot_index: SLOT_W'(i), status: STATUS_OK,
                                          last: (left == 0)});
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
      mismatch_count++;
   endtask

   // Compare each accepted result word with the oldest one due, field by field.
   always @(posedge clock) begin
      rsp_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (slot_words_due.size() == 0) begin
            report_mismatch("unexpected word", '0, 16'(rsp_word));
         end else begin
            due = slot_words_due.pop_front();
            if (rsp_word.slot_index !== due.slot_index)
               report_mismatch("slot_index", 16'(due.slot_index), 16'(rsp_word.slot_index));
            if (rsp_word.status !== due.status)
               report_mismatch("status", 16'(due.status), 16'(rsp_word.status));
            if (rsp_word.last !== due.last)
               report_mismatch("last", 16'(due.last), 16'(rsp_word.last));
         end
      end
   end

   // Give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // Receiver: hold off for a long stretch on request, otherwise drop ready
   // at random unless idling is switched off.
   always @(posedge clock) begin
      if (stall_go) begin
         stall_go   = 1'b0;
         stall_left = STALL_HOLD_CYCLES;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!idling_on) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // Sender and configuration
   // ------------------------------------------------------------------

   // Offer one request word, perhaps after a short gap, hold it until it is
   // accepted and predict its results at the accepting edge. Valid is left
   // high so that back-to-back words need no second assignment.
   task automatic send_request(cmd_type c, int unsigned n);
      req_word_type w;
      w.cmd           = c;
      w.request_count = COUNT_W'(n);
      if (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      predict_request(w);
   endtask

   // Drop valid, wait for every due word, then let the block finish its
   // last request before anything else happens.
   task automatic settle();
      req_valid <= 1'b0;
      while (slot_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the active length; call only after settle.
   task automatic set_active_slots(int unsigned value);
      csr_we    <= 1'b1;
      csr_wdata <= COUNT_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      slot_span = (value > SLOT_TOTAL) ? SLOT_TOTAL : value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty requests and requests that cannot be met on an empty map.
   task automatic test_empty_and_short();
      send_request(CMD_ALLOC, 0);
      send_request(CMD_RELEASE, 0);
      send_request(CMD_RELEASE, 1);
      send_request(CMD_ALLOC, 65);
      send_request(CMD_ALLOC, 127);
   endtask

   // Fill the whole map, overflow it, drain it, then reuse holes lowest first.
   task automatic test_fill_and_drain();
      send_request(CMD_ALLOC, 64);
      send_request(CMD_ALLOC, 1);
      send_request(CMD_RELEASE, 127);
      send_request(CMD_RELEASE, 64);
      send_request(CMD_ALLOC, 3);
      send_request(CMD_ALLOC, 2);
      send_request(CMD_RELEASE, 1);
      send_request(CMD_ALLOC, 1);
      send_request(CMD_RELEASE, 5);
   endtask

   // Shrink the active length over used slots: slots above it must be
   // neither taken nor freed. Then cover zero, one and a saturating value.
   task automatic test_active_length();
      settle();
      set_active_slots(64);
      send_request(CMD_ALLOC, 10);
      settle();
      set_active_slots(4);
      send_request(CMD_RELEASE, 4);
      send_request(CMD_RELEASE, 1);
      send_request(CMD_ALLOC, 4);
      settle();
      set_active_slots(0);
      send_request(CMD_ALLOC, 1);
      send_request(CMD_RELEASE, 0);
      settle();
      set_active_slots(1);
      send_request(CMD_RELEASE, 1);
      send_request(CMD_ALLOC, 1);
      settle();
      set_active_slots(127);
      send_request(CMD_ALLOC, 54);
      send_request(CMD_RELEASE, 64);
      send_request(CMD_RELEASE, 10);
      settle();
   endtask

   // Mostly requests that can be served, sized from the current map so that
   // it fills and empties; some noise with any count.
   task automatic random_request();
      int unsigned roll, avail, n;
      cmd_type     c;
      roll = $urandom_range(99);
      if (roll < 12) begin
         c = cmd_type'($urandom_range(1));
         n = $urandom_range(127);
      end else begin
         if (matching_slots(CMD_ALLOC) == 0)
            c = CMD_RELEASE;
         else if (matching_slots(CMD_RELEASE) == 0)
            c = CMD_ALLOC;
         else
            c = cmd_type'($urandom_range(1));
         avail = matching_slots(c);
         if (avail == 0)
            n = $urandom_range(1, 3);
         else if (roll < 17)
            n = avail;
         else
            n = $urandom_range(1, (avail < 6) ? avail : 6);
      end
      send_request(c, n);
   endtask

   task automatic test_random_traffic(int unsigned active, int unsigned items);
      settle();
      set_active_slots(active);
      repeat (items) random_request();
      settle();
   endtask

   // Hold the receiver off while the sender keeps offering words, so the
   // block fills up and stalls its input.
   task automatic test_backpressure();
      settle();
      stall_go = 1'b1;
      repeat (12) send_request(cmd_type'($urandom_range(1)), $urandom_range(0, 4));
      settle();
   endtask

   // A stretch with no idling on either side.
   task automatic test_full_rate();
      settle();
      idling_on = 1'b0;
      set_active_slots(64);
      repeat (40) random_request();
      settle();
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_short();
      test_fill_and_drain();
      test_active_length();
      test_backpressure();
      test_random_traffic(64, 70);
      test_random_traffic(1, 30);
      test_random_traffic(2, 30);
      test_random_traffic($urandom_range(3, 62), 60);
      test_full_rate();
      test_random_traffic(127, 60);
      test_random_traffic(0, 10);
      test_random_traffic(63, 40);
      test_random_traffic(64, 60);
      settle();
      if (mismatch_count == 0 && slot_words_due.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
